// ===== design/sobel_pkg.sv =====
`default_nettype none
package sobel_pkg;

  localparam int MAX_WIDTH_DEF     = 2048;
  localparam int MAX_HEIGHT_DEF    = 2048;
  localparam int IMAGE_WIDTH_RESET = 640;
  localparam int MIN_WIDTH         = 3;
  // a window is complete once two earlier columns or rows have passed
  localparam int WIN_FILL          = 2;

  localparam int CFG_W       = 12;
  localparam int PIXEL_W     = 8;
  localparam int COORD_W     = 11;
  localparam int GRAD_W      = 11;
  localparam int MAG_MAX     = 255;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  typedef struct packed {
    grad_t  gx;
    grad_t  gy;
    coord_t col;
    coord_t row;
  } grad_beat_t;

  function automatic grad_t widen(input pixel_t p);
    widen = $signed({{(GRAD_W-PIXEL_W){1'b0}}, p});
  endfunction

endpackage
`default_nettype wire

// ===== design/sobel_ram.sv =====
`default_nettype none
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/sobel_grad.sv =====
`default_nettype none
module sobel_grad (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 adv,
  input  wire logic                 emit,
  input  wire sobel_pkg::pixel_t    px,
  input  wire sobel_pkg::pixel_t    top,
  input  wire sobel_pkg::pixel_t    mid,
  input  wire sobel_pkg::coord_t    ccol,
  input  wire sobel_pkg::coord_t    crow,
  input  wire logic                 mag_ready,
  output logic                      ready,
  output logic                      beat_valid,
  output sobel_pkg::grad_beat_t     beat
);

  // [0..2] column col-2 (top, mid, bot), [3..5] column col-1
  sobel_pkg::pixel_t win [6];
  sobel_pkg::grad_t  tl, l, bl, tm, bm, tr, r, br;
  sobel_pkg::grad_t  gx, gy;

  always_comb begin
    tl = sobel_pkg::widen(win[0]);
    l  = sobel_pkg::widen(win[1]);
    bl = sobel_pkg::widen(win[2]);
    tm = sobel_pkg::widen(win[3]);
    bm = sobel_pkg::widen(win[5]);
    tr = sobel_pkg::widen(top);
    r  = sobel_pkg::widen(mid);
    br = sobel_pkg::widen(px);
    gx = tr + br - tl - bl + r + r - l - l;
    gy = tl + tr - bl - br + tm + tm - bm - bm;
  end

  assign ready = !beat_valid || mag_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (ready) begin
      beat_valid <= adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && adv && emit) begin
      beat <= '{gx: gx, gy: gy, col: ccol, row: crow};
    end
  end

endmodule
`default_nettype wire

// ===== design/sobel_mag.sv =====
`default_nettype none
module sobel_mag (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   beat_valid,
  input  wire sobel_pkg::grad_beat_t                  beat,
  output logic                                        ready,
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  output logic [sobel_pkg::OUT_TDATA_W-1:0]           m_tdata
);

  logic [sobel_pkg::GRAD_W-1:0] ax, ay;
  logic [sobel_pkg::GRAD_W:0]   sum;
  sobel_pkg::pixel_t            mag;

  always_comb begin
    ax  = beat.gx[sobel_pkg::GRAD_W-1] ? $unsigned(-beat.gx) : $unsigned(beat.gx);
    ay  = beat.gy[sobel_pkg::GRAD_W-1] ? $unsigned(-beat.gy) : $unsigned(beat.gy);
    sum = {1'b0, ax} + {1'b0, ay};
    if (sum > (sobel_pkg::GRAD_W+1)'(sobel_pkg::MAG_MAX)) begin
      mag = sobel_pkg::PIXEL_W'(sobel_pkg::MAG_MAX);
    end else begin
      mag = sum[sobel_pkg::PIXEL_W-1:0];
    end
  end

  assign ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ready) begin
      m_tvalid <= beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && beat_valid) begin
      m_tdata <= sobel_pkg::OUT_TDATA_W'({beat.row, beat.col, mag});
    end
  end

endmodule
`default_nettype wire

// ===== design/sobel_edge_magnitude_core.sv =====
// Sobel 3x3 edge magnitude on a raster-order grayscale pixel stream.
// Input beats (s_*) carry one 8-bit pixel each; s_tuser marks the first pixel
// of a frame and clears the row and column counters. Output beats (m_*) carry
// min(|Gx|+|Gy|, 255) with the column and row of the window center; border
// pixels (first and last row and column) give no beat.
// The row length is set through cfg_we / cfg_wdata; the user must write it
// while the stream is idle, which the block does not enforce; values below 3
// act as 3 and values above MAX_WIDTH act as MAX_WIDTH. Throughput is one pixel
// per clock unless a result is held in the read stage: the two line stores sit in
// simple dual-port synchronous RAMs (one read port, one write port), read for
// the incoming column and written back when the pixel leaves the read stage,
// with a bypass when the next pixel reads the column just written. m_tvalid
// follows the last pixel of a window through read, gradient and output stages.
// When m_tready is low, up to three results wait inside (output register,
// gradient register and the pixel in the read stage) while pixels that give
// no result keep flowing; s_tready drops once both registers are full and a
// pixel with a result sits in the read stage.
// Reset clears the counters, the window and the pipeline and sets the width to
// 640; the line stores are not cleared, so the first two rows after reset or
// after widening the image only refill them.
`default_nettype none
module sobel_edge_magnitude_core #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [sobel_pkg::CFG_W-1:0]          cfg_wdata,   // image_width
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [sobel_pkg::IN_TDATA_W-1:0]     s_tdata,     // [7:0] pixel
  input  wire logic                                 s_tuser,     // frame_start
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [7:0] magnitude, [18:8] center_col, [29:19] center_row, [31:30] zero
  output logic [sobel_pkg::OUT_TDATA_W-1:0]         m_tdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int WIDTH_RESET =
    (sobel_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : sobel_pkg::IMAGE_WIDTH_RESET;
  localparam logic [RW-1:0] ROW_LIMIT = RW'(MAX_HEIGHT);

  logic [WW-1:0] width, width_clamped;
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next, row_base;
  logic [CW-1:0] col_base;
  logic [WW-1:0] col_cur, col_inc;
  logic          wrap, emit, accept;

  // first stage: RAM read in flight
  logic              s1_valid, s1_emit, s1_adv, s1_fwd;
  logic [CW-1:0]     s1_col;
  sobel_pkg::pixel_t s1_px, s1_fwd_top, s1_fwd_mid;
  sobel_pkg::coord_t s1_ccol, s1_crow;
  sobel_pkg::pixel_t ram_top, ram_mid, top_eff, mid_eff;

  logic                  grad_ready, mag_ready, beat_valid;
  sobel_pkg::grad_beat_t beat;

  always_comb begin
    if (cfg_wdata < sobel_pkg::CFG_W'(sobel_pkg::MIN_WIDTH)) begin
      width_clamped = WW'(sobel_pkg::MIN_WIDTH);
    end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width <= WW'(WIDTH_RESET);
    end else if (cfg_we) begin
      width <= width_clamped;
    end
  end

  // position of the incoming pixel
  always_comb begin
    col_base = s_tuser ? '0 : column_count;
    row_base = s_tuser ? '0 : row_count;
    // a narrowed width ends the current row at once
    col_cur  = (WW'(col_base) >= width) ? '0 : WW'(col_base);
    col_inc  = col_cur + WW'(1);
    wrap     = col_inc >= width;
    column_count_next = wrap ? '0 : CW'(col_inc);
    if (wrap && row_base < ROW_LIMIT) begin
      row_count_next = row_base + RW'(1);
    end else begin
      row_count_next = row_base;
    end
    emit = (col_cur >= WW'(sobel_pkg::WIN_FILL)) && (row_base >= RW'(sobel_pkg::WIN_FILL))
           && (row_base < ROW_LIMIT);
  end

  assign s1_adv   = s1_valid && (!s1_emit || grad_ready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= CW'(col_cur);
      s1_px      <= s_tdata[sobel_pkg::PIXEL_W-1:0];
      s1_emit    <= emit;
      s1_ccol    <= sobel_pkg::COORD_W'(col_cur - WW'(1));
      s1_crow    <= sobel_pkg::COORD_W'(row_base - RW'(1));
      // bypass when the RAM write of the leaving pixel hits the same column
      s1_fwd     <= s1_adv && (s1_col == CW'(col_cur));
      s1_fwd_top <= mid_eff;
      s1_fwd_mid <= s1_px;
    end
  end

  assign top_eff = s1_fwd ? s1_fwd_top : ram_top;
  assign mid_eff = s1_fwd ? s1_fwd_mid : ram_mid;

  sobel_ram #(
    .WIDTH(sobel_pkg::PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store_upper (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_col),
    .wdata(mid_eff),
    .re   (accept),
    .raddr(CW'(col_cur)),
    .rdata(ram_top)
  );

  sobel_ram #(
    .WIDTH(sobel_pkg::PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store_middle (
    .clk  (clk),
    .we   (s1_adv),
    .waddr(s1_col),
    .wdata(s1_px),
    .re   (accept),
    .raddr(CW'(col_cur)),
    .rdata(ram_mid)
  );

  sobel_grad u_grad (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_adv),
    .emit      (s1_emit),
    .px        (s1_px),
    .top       (top_eff),
    .mid       (mid_eff),
    .ccol      (s1_ccol),
    .crow      (s1_crow),
    .mag_ready (mag_ready),
    .ready     (grad_ready),
    .beat_valid(beat_valid),
    .beat      (beat)
  );

  sobel_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .beat_valid(beat_valid),
    .beat      (beat),
    .ready     (mag_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> WW'(column_count) < width)
    else $error("column counter past row end");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= ROW_LIMIT)
    else $error("row counter past limit");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_col) && $stable(s1_px))
    else $error("stalled pixel lost its column");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && !grad_ready |-> !s_tready)
    else $error("pixel accepted over a stalled one");

endmodule
`default_nettype wire
